// ===== rtl/trial_division_prime_test_macros.svh =====
// Assertion helpers for the prime test block.
// They assume a clock named i_clk and an active-low reset named i_rst_n.
`ifndef TRIAL_DIVISION_PRIME_TEST_MACROS_SVH
`define TRIAL_DIVISION_PRIME_TEST_MACROS_SVH

// Same-cycle implication.
`define TDP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tdp assertion failed");

// Next-cycle implication.
`define TDP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tdp assertion failed");

`endif

// ===== rtl/tdp_pkg.sv =====
package tdp_pkg;

    localparam int DEF_NUMBER_WIDTH = 32;

    // fixed divisors and wheel step
    localparam int C_TWO   = 2;
    localparam int C_THREE = 3;
    localparam int C_FIVE  = 5;
    localparam int C_SIX   = 6;

    // sequencer states
    localparam int         ST_W     = 3;
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV3  = 3'd1;
    localparam logic [2:0] ST_DIVF  = 3'd2;
    localparam logic [2:0] ST_DIVF2 = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

endpackage

// ===== rtl/tdp_divider.sv =====
// Restoring divider, one quotient bit per cycle.
module tdp_divider #(
    parameter int W = tdp_pkg::DEF_NUMBER_WIDTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_busy,
    output logic         o_done,
    output logic [W-1:0] o_quotient,
    output logic [W-1:0] o_remainder
);

    localparam int CW = $clog2(W);

    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [W-1:0]  r_quo;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_dvs;

    logic [W:0]    rem_sh;
    logic [W:0]    diff;
    logic          take;

    always_comb begin
        rem_sh = {r_rem, r_quo[W-1]};
        diff   = rem_sh - {1'b0, r_dvs};
        take   = (rem_sh >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= take ? diff[W-1:0] : rem_sh[W-1:0];
            r_quo <= {r_quo[W-2:0], take};
        end
    end

    assign o_busy      = r_busy;
    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// ===== rtl/trial_division_prime_test.sv =====
// Trial-division primality test, 6k +/- 1 wheel.
// Input channel: i_valid / o_stall carry one NUMBER_WIDTH-bit candidate per beat;
//   a beat is taken at a clock edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall carry one o_is_prime bit per beat.
// One candidate is worked at a time; o_stall stays high from acceptance until
//   the answer moves into the output register.
// Numbers below 2 and even numbers are settled without the divider. Odd numbers
//   run a restoring divider: one division by 3, then two per wheel pair f, f+2
//   while f*f <= n. The bound is checked as f <= n / f using the same division's
//   quotient. All divisions go through the one shared divider.
// Reset (synchronous, active low) returns the sequencer to idle and drops
//   o_valid; nothing else is kept between numbers.
// If the receiver stalls, the answer holds in the output register; the block
//   may accept the next candidate meanwhile, and that candidate waits in its
//   final state until the output register frees up.
`include "trial_division_prime_test_macros.svh"

module trial_division_prime_test #(
    parameter int NUMBER_WIDTH = tdp_pkg::DEF_NUMBER_WIDTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [NUMBER_WIDTH-1:0] i_candidate,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic                    o_is_prime
);

    import tdp_pkg::*;

    localparam int W = NUMBER_WIDTH;

    // sequencer and output registers
    logic [ST_W-1:0] r_state, n_state;
    logic [W-1:0]    r_n, n_n;       // number under test
    logic [W-1:0]    r_f, n_f;       // current wheel base, 6k - 1
    logic            r_result, n_result;
    logic            r_out_valid, n_out_valid;
    logic            r_is_prime, n_is_prime;

    // shared divider
    logic            div_start;
    logic [W-1:0]    div_dividend;
    logic [W-1:0]    div_divisor;
    logic            div_busy;
    logic            div_done;
    logic [W-1:0]    div_quo;
    logic [W-1:0]    div_rem;

    logic            in_acc;

    assign o_stall = (r_state != ST_IDLE);
    assign in_acc  = i_valid && !o_stall;

    tdp_divider #(
        .W (W)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_busy      (div_busy),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    always_comb begin
        n_state      = r_state;
        n_n          = r_n;
        n_f          = r_f;
        n_result     = r_result;
        n_out_valid  = r_out_valid && i_stall;   // beat leaves when not stalled
        n_is_prime   = r_is_prime;
        div_start    = 1'b0;
        div_divisor  = r_f + W'(C_TWO);
        div_dividend = (r_state == ST_IDLE) ? i_candidate : r_n;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_n = i_candidate;
                    if (i_candidate < W'(C_TWO)) begin
                        n_result = 1'b0;
                        n_state  = ST_FIN;
                    end else if (!i_candidate[0]) begin
                        // even: only 2 is prime
                        n_result = (i_candidate == W'(C_TWO));
                        n_state  = ST_FIN;
                    end else begin
                        div_start   = 1'b1;
                        div_divisor = W'(C_THREE);
                        n_state     = ST_DIV3;
                    end
                end
            end
            ST_DIV3: begin
                if (div_done) begin
                    if (div_rem == '0) begin
                        n_result = (r_n == W'(C_THREE));
                        n_state  = ST_FIN;
                    end else begin
                        n_f         = W'(C_FIVE);
                        div_start   = 1'b1;
                        div_divisor = W'(C_FIVE);
                        n_state     = ST_DIVF;
                    end
                end
            end
            ST_DIVF: begin
                if (div_done) begin
                    if (r_f > div_quo) begin
                        // f*f > n: no factor left to find
                        n_result = 1'b1;
                        n_state  = ST_FIN;
                    end else if (div_rem == '0) begin
                        n_result = 1'b0;
                        n_state  = ST_FIN;
                    end else begin
                        div_start   = 1'b1;
                        div_divisor = r_f + W'(C_TWO);
                        n_state     = ST_DIVF2;
                    end
                end
            end
            ST_DIVF2: begin
                if (div_done) begin
                    if (div_rem == '0) begin
                        n_result = 1'b0;
                        n_state  = ST_FIN;
                    end else begin
                        n_f         = r_f + W'(C_SIX);
                        div_start   = 1'b1;
                        div_divisor = r_f + W'(C_SIX);
                        n_state     = ST_DIVF;
                    end
                end
            end
            ST_FIN: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_is_prime  = r_result;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n        <= n_n;
        r_f        <= n_f;
        r_result   <= n_result;
        r_is_prime <= n_is_prime;
    end

    assign o_valid    = r_out_valid;
    assign o_is_prime = r_is_prime;

    // checks
    `TDP_ASSERT_NXT(a_accept_leaves_idle, in_acc, r_state != ST_IDLE)
    `TDP_ASSERT_IMP(a_start_when_free, div_start, !div_busy)
    `TDP_ASSERT_IMP(a_wheel_odd, r_state == ST_DIVF || r_state == ST_DIVF2, r_f[0] && (r_f >= W'(C_FIVE)))
    `TDP_ASSERT_IMP(a_prime_odd_or_two, r_state == ST_FIN && r_result, r_n[0] || (r_n == W'(C_TWO)))

endmodule

// ===== verif/trial_division_prime_test_checker.sv =====
module trial_division_prime_test_checker #(
    parameter int NUMBER_WIDTH = tdp_pkg::DEF_NUMBER_WIDTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_stall,
    input  logic [NUMBER_WIDTH-1:0] i_candidate,
    input  logic                    i_out_valid,
    input  logic                    i_out_stall,
    input  logic                    i_is_prime,
    output int                      o_fail_count,
    output int                      o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import tdp_pkg::*;

    typedef struct packed {
        logic [NUMBER_WIDTH-1:0] candidate;
        logic                    is_prime;
    } t_verdict;

    t_verdict pending_verdicts[$];
    int       fail_total = 0;

    // 6k +/- 1 wheel, bound kept exact at 64 bits
    function automatic logic wheel_is_prime(input logic [NUMBER_WIDTH-1:0] num);
        longint unsigned n;
        longint unsigned f;
        n = num;
        if (n < C_TWO) return 1'b0;
        if (n % C_TWO == 0) return n == C_TWO;
        if (n % C_THREE == 0) return n == C_THREE;
        for (f = C_FIVE; f * f <= n; f += C_SIX) begin
            if (n % f == 0 || n % (f + C_TWO) == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_verdict oldest;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall)
                pending_verdicts.push_back('{i_candidate, wheel_is_prime(i_candidate)});
            if (i_out_valid && !i_out_stall) begin
                if (pending_verdicts.size() == 0) begin
                    fail_total++;
                    $display("%0t: unexpected result beat: expected none, got is_prime=%0b",
                             $time, i_is_prime);
                end else begin
                    oldest = pending_verdicts.pop_front();
                    if (i_is_prime !== oldest.is_prime) begin
                        fail_total++;
                        $display("%0t: is_prime for %0d: expected %0b, got %0b",
                                 $time, oldest.candidate, oldest.is_prime, i_is_prime);
                    end
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= pending_verdicts.size();
    end

endmodule

// ===== verif/trial_division_prime_test_tb.sv =====
module trial_division_prime_test_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NW          = tdp_pkg::DEF_NUMBER_WIDTH;
    // The slowest sane run, dominated by one 32-bit prime, stays well under
    // this limit; past it the run is called hung.
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int RANDOM_BEATS = 80;

    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          i_valid     = 1'b0;
    logic [NW-1:0] i_candidate = '0;
    logic          i_stall     = 1'b0;
    logic          o_stall;
    logic          o_valid;
    logic          o_is_prime;

    int fail_count;
    int pending;

    // When set, neither side inserts gaps or stalls.
    bit no_gaps = 1'b0;

    always #10 i_clk = ~i_clk;

    trial_division_prime_test #(
        .NUMBER_WIDTH(NW)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_candidate(i_candidate),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_is_prime (o_is_prime)
    );

    trial_division_prime_test_checker #(
        .NUMBER_WIDTH(NW)
    ) i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_stall  (o_stall),
        .i_candidate (i_candidate),
        .i_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_is_prime  (o_is_prime),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Hang guard.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("FAIL");
        $finish;
    end

    // Result side: random stall before each beat, then hold stall low until a
    // beat goes through. Stalling with o_valid low is fine.
    always begin : result_sink
        int hold;
        hold = no_gaps ? 0 : $urandom_range(0, 15);
        if (hold > 0) begin
            i_stall <= 1'b1;
            repeat (hold) @(posedge i_clk);
        end
        i_stall <= 1'b0;
        do @(posedge i_clk); while (!(o_valid && !i_stall));
    end

    // One candidate beat: optional gap with valid low, then present the
    // number and wait for the block to take it. Valid stays high on return
    // so back-to-back beats keep it up without a drop.
    task automatic send_candidate(input logic [NW-1:0] value);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_candidate <= value;
        do @(posedge i_clk); while (!(i_valid && !o_stall));
    endtask

    // Drop valid and hold off until every answer in flight has come back.
    // At least one edge passes, so valid is never lowered and raised in
    // the same step.
    task automatic drain_answers();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Random candidate, sized so the run stays short: mostly small numbers,
    // some mid-size, and full-width ones forced onto a small factor so that
    // every bit toggles without paying for a 32-bit prime each time.
    function automatic logic [NW-1:0] pick_candidate();
        logic [31:0] raw;
        int          kind;
        int          factor;
        kind = $urandom_range(0, 9);
        raw  = $urandom;
        if (kind <= 5) return $urandom_range(0, 4095);
        if (kind <= 7) return $urandom_range(0, (1 << 18) - 1);
        case ($urandom_range(0, 5))
            0: factor = 2;
            1: factor = 3;
            2: factor = 5;
            3: factor = 7;
            4: factor = 11;
            default: factor = 13;
        endcase
        return raw - (raw % factor);
    endfunction

    logic [31:0] directed_set[$] = '{
        32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd7, 32'd9,
        32'd25,          // f*f == n, first wheel divisor
        32'd35,          // caught by f, not f+2
        32'd49, 32'd121,
        32'd169,         // square of a f+2 divisor
        32'd289, 32'd323, // third wheel pair
        32'd65521,       // largest 16-bit prime
        32'd65535,
        32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000,
        32'hAAAA_AAAA, 32'h5555_5555,
        32'd4294967291   // largest 32-bit prime, the slow extreme
    };

    initial begin
        // Reset once, then release.
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed corners first.
        foreach (directed_set[k])
            send_candidate(directed_set[k][NW-1:0]);

        // Let everything drain before random traffic starts.
        drain_answers();

        for (int k = 0; k < RANDOM_BEATS; k++) begin
            // A back-to-back stretch in the middle; gaps elsewhere.
            no_gaps = (k >= 40 && k < 60);
            if (k == 75)
                drain_answers();
            send_candidate(pick_candidate());
        end
        no_gaps = 1'b0;

        drain_answers();
        // Short tail: anything extra would show up as an unexpected beat.
        repeat (50) @(posedge i_clk);

        if (pending != 0)
            $display("%0t: %0d answers never arrived", $time, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
